// ===== rtl/tdp_pkg.sv =====
// Shared constants and types for the trial division prime tester.
package tdp_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int DIV_WIDTH  = DATA_WIDTH / 2 + 1;
	localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

	typedef struct packed {
		logic busy;
		logic done;
		logic rem_zero;
	} tdp_div_status_t;

endpackage

// ===== rtl/tdp_if.sv =====
// Valid/ready channel interfaces for candidate and result beats.
interface tdp_in_if import tdp_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] candidate;
	logic                         last_in_range;

	modport source (output valid, candidate, last_in_range, input ready);
	modport sink (input valid, candidate, last_in_range, output ready);
endinterface

interface tdp_out_if import tdp_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] number;
	logic                         is_prime;
	logic                         end_of_range;

	modport source (output valid, number, is_prime, end_of_range, input ready);
	modport sink (input valid, number, is_prime, end_of_range, output ready);
endinterface

// ===== rtl/tdp_divider.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module tdp_divider import tdp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DIV_WIDTH-1:0]  divisor,
	output tdp_div_status_t       status
);

	logic [DIV_WIDTH-1:0]  rem_q;
	logic [DIV_WIDTH-1:0]  dsr_q;
	logic [DATA_WIDTH-1:0] dvd_q;
	logic [CNT_WIDTH-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIV_WIDTH:0]    trial;
	logic [DIV_WIDTH:0]    diff;
	logic                  fits;

	assign trial = {rem_q, dvd_q[DATA_WIDTH-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_WIDTH'(DATA_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
			dvd_q <= {dvd_q[DATA_WIDTH-2:0], 1'b0};
		end
	end

	assign status.busy     = busy_q;
	assign status.done     = done_q;
	assign status.rem_zero = rem_q == '0;

endmodule

// ===== rtl/trial_division_prime_test_top.sv =====
// Top level of the trial division prime tester: sequencer, square tracker and result register.
//
//   channel     role   beat contents
//   candidates  sink   candidate, last_in_range
//   results     source number, is_prime, end_of_range
//
// Each trial divisor d takes one full pass of the bit-serial remainder
// unit, and up to floor(sqrt(v)) - 1 divisors are tried, so a prime
// near the top of the range takes the longest. Negative values, zero and one
// skip the divisor loop. Reset only clears control state; there is no memory.
// A finished result waits in its own register, so a new candidate is taken
// while it stalls; a second result waits until the first beat is taken.
module trial_division_prime_test_top import tdp_pkg::*; (
	input logic clk,
	input logic arst_n,
	tdp_in_if.sink candidates,
	tdp_out_if.source results
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                state_q;
	logic [DATA_WIDTH-1:0] v_q;
	logic                  last_q;
	logic                  prime_q;
	logic [DIV_WIDTH-1:0]  d_q;
	logic [DATA_WIDTH-1:0] sq_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_num_q;
	logic                  out_prime_q;
	logic                  out_end_q;
	logic                  in_beat;
	logic                  div_start;
	logic                  load_out;
	logic                  small_val;
	tdp_div_status_t       div_status;

	assign candidates.ready = state_q == ST_IDLE;
	assign in_beat   = candidates.valid && candidates.ready;
	assign small_val = candidates.candidate[DATA_WIDTH-1] ||
		(candidates.candidate <= DATA_WIDTH'(1));
	assign div_start = (state_q == ST_CHECK) && (sq_q <= v_q);
	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || results.ready);

	tdp_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_q),
		.divisor  (d_q),
		.status   (div_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= small_val ? ST_FINISH : ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= div_start ? ST_DIV : ST_FINISH;
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= div_status.rem_zero ? ST_FINISH : ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			v_q     <= candidates.candidate;
			last_q  <= candidates.last_in_range;
			prime_q <= 1'b0;
			d_q     <= DIV_WIDTH'(2);
			sq_q    <= DATA_WIDTH'(4);
		end else if (state_q == ST_CHECK && !div_start) begin
			prime_q <= 1'b1;
		end else if (state_q == ST_DIV && div_status.done) begin
			d_q  <= d_q + 1'b1;
			sq_q <= sq_q + DATA_WIDTH'({d_q, 1'b1});
		end
		if (load_out) begin
			out_num_q   <= v_q;
			out_prime_q <= prime_q;
			out_end_q   <= last_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.number       = out_num_q;
	assign results.is_prime     = out_prime_q;
	assign results.end_of_range = out_end_q;

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !candidates.ready)
		else $error("candidate accepted while a test was running");

	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (sq_q == DATA_WIDTH'(d_q * d_q)))
		else $error("running square does not match trial divisor");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_status.busy)
		else $error("remainder unit restarted while busy");

	a_prime_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.is_prime) |-> !results.number[DATA_WIDTH-1])
		else $error("negative value reported as prime");

endmodule

// ===== tb/prime_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker that predicts the primality verdict of each accepted candidate and compares results.
module prime_result_checker import tdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tdp_in_if           cand_ch,
	tdp_out_if          res_ch,
	output int unsigned mismatch_count,
	output int unsigned awaited_count
);

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] number;
		logic                         is_prime;
		logic                         end_of_range;
	} verdict_t;

	verdict_t awaited_results[$];

	function automatic logic primality_of(logic [DATA_WIDTH-1:0] value);
		logic [DATA_WIDTH-1:0] divisor;
		if (value[DATA_WIDTH-1] || value <= 1) return 1'b0;
		if (value == 2) return 1'b1;
		for (divisor = 2; divisor <= value / divisor; divisor++) begin
			if (value % divisor == 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		verdict_t oldest;
		if (arst_n) begin
			if (cand_ch.valid && cand_ch.ready) begin
				awaited_results.push_back('{cand_ch.candidate, primality_of(cand_ch.candidate),
					cand_ch.last_in_range});
			end
			if (res_ch.valid && res_ch.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result beat for %0d with no candidate waiting",
						res_ch.number));
				end else begin
					oldest = awaited_results.pop_front();
					if (res_ch.number !== oldest.number)
						report_mismatch($sformatf("number %0d, expected %0d",
							res_ch.number, oldest.number));
					if (res_ch.is_prime !== oldest.is_prime)
						report_mismatch($sformatf("is_prime %b for %0d, expected %b",
							res_ch.is_prime, oldest.number, oldest.is_prime));
					if (res_ch.end_of_range !== oldest.end_of_range)
						report_mismatch($sformatf("end_of_range %b for %0d, expected %b",
							res_ch.end_of_range, oldest.number, oldest.end_of_range));
				end
			end
			awaited_count = awaited_results.size();
		end
	end

endmodule

// ===== tb/trial_division_prime_test_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top that drives candidate beats, throttles results and prints the verdict.
module trial_division_prime_test_top_tb;
	import tdp_pkg::*;

	localparam longint CYCLE_LIMIT  = 30_000_000;
	localparam int     DRAIN_CYCLES = 200;
	localparam int     HOLD_CYCLES  = 600;
	localparam int     PHASE_BEATS  = 28;

	localparam int DIRECTED_VALUES[21] = '{
		0, 1, 2, 3, 4, 5, 9, 25, 49, 121, 169, 7919, 63001, 65521, 65535,
		-1, -2, int'(32'h8000_0000), int'(32'h7fff_fffe), int'(32'h7fff_fffd),
		int'(32'h7fff_ffff)
	};
	localparam int          CORNER_VALUES[6]  = '{0, 1, 2, 3, -1, int'(32'h8000_0000)};
	localparam int unsigned SMALL_FACTORS[6]  = '{2, 3, 5, 7, 11, 13};
	localparam int          SENDER_IDLE[4]    = '{0, 47, 0, 23};
	localparam int          RECEIVER_STALL[4] = '{0, 0, 47, 23};

	logic        clk;
	logic        arst_n;
	longint      cycle_count;
	int          sender_idle_pct;
	int          receiver_stall_pct;
	int          hold_requests;
	int          hold_served;
	int          hold_left;
	int unsigned mismatch_count;
	int unsigned awaited_count;

	tdp_in_if  cand_ch();
	tdp_out_if res_ch();

	trial_division_prime_test_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.candidates(cand_ch),
		.results   (res_ch)
	);

	prime_result_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cand_ch       (cand_ch),
		.res_ch        (res_ch),
		.mismatch_count(mismatch_count),
		.awaited_count (awaited_count)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// A long hold-off lets the block fill up and push back on the candidate channel.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	function automatic logic signed [DATA_WIDTH-1:0] random_candidate();
		int unsigned kind;
		int unsigned factor;
		kind = $urandom_range(99);
		if (kind < 40) return $urandom_range(4095);
		if (kind < 58) return $urandom_range(20'hf_ffff);
		if (kind < 73) return {1'b1, 31'($urandom)};
		if (kind < 88) begin
			factor = SMALL_FACTORS[$urandom_range(5)];
			return factor * $urandom_range(32'h7fff_ffff / factor, 2);
		end
		return CORNER_VALUES[$urandom_range(5)];
	endfunction

	task automatic send_beat(input logic signed [DATA_WIDTH-1:0] value, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			cand_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cand_ch.valid         <= 1'b1;
		cand_ch.candidate     <= value;
		cand_ch.last_in_range <= last;
		do @(posedge clk); while (!cand_ch.ready);
		@(negedge clk);
	endtask

	initial begin
		cand_ch.valid         = 1'b0;
		cand_ch.candidate     = '0;
		cand_ch.last_in_range = 1'b0;
		arst_n                = 1'b0;
		sender_idle_pct       = 0;
		receiver_stall_pct    = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED_VALUES[idx])
			send_beat(DIRECTED_VALUES[idx], (idx % 4) == 3 || idx == $size(DIRECTED_VALUES) - 1);

		hold_requests++;
		repeat (6) send_beat($urandom_range(60), 1'($urandom_range(1)));
		cand_ch.valid <= 1'b0;
		wait (awaited_count == 0);
		@(negedge clk);

		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct    = SENDER_IDLE[phase];
			receiver_stall_pct = RECEIVER_STALL[phase];
			repeat (PHASE_BEATS) send_beat(random_candidate(), 1'($urandom_range(1)));
		end
		cand_ch.valid <= 1'b0;

		wait (awaited_count == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && awaited_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tdp_pkg.sv
rtl/tdp_if.sv
rtl/tdp_divider.sv
rtl/trial_division_prime_test_top.sv
tb/prime_result_checker.sv
tb/trial_division_prime_test_top_tb.sv
